// ----- hdl/fndf_pkg.sv -----
// Shared types and constants of the four-neighbour deglitch filter.
// Used by the column cells, the judge unit and the top level; depends on nothing.
package fndf_pkg;

    // Default frame limits, handed to the top-level parameters.
    localparam int FNDF_MAX_WIDTH  = 1024;
    localparam int FNDF_MAX_HEIGHT = 1024;

    // Configuration port geometry.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [7:0]       RST_TOLERANCE    = 8'd1;

    typedef logic [7:0] t_pix;

    // One column of the window: two rows above the newest row, the row above, the newest row.
    typedef struct packed {
        t_pix up;
        t_pix mid;
        t_pix low;
    } t_col;

    // Line store word: the row above and the row two above, for one column.
    typedef struct packed {
        t_pix centre;
        t_pix above;
    } t_pair;

    // Position flags of the column held in the judge stage.
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic row_last;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } t_pos;

    // One result beat.
    typedef struct packed {
        t_pix pixel;
        logic replaced;
        logic last;
    } t_res;

endpackage

// ----- hdl/fndf_ram.sv -----
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module fndf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fndf_cell.sv -----
// One column cell of the sliding window: holds three vertically adjacent pixels.
// Depends on fndf_pkg for the column type.
module fndf_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  fndf_pkg::t_col i_col,
    output fndf_pkg::t_col o_col
);
    import fndf_pkg::*;

    t_col r_col;

    // The cell takes the column of the cell before it in the chain on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// ----- hdl/fndf_judge.sv -----
// Glitch decision for one pixel against up to four neighbours, with rounded average.
// Depends on fndf_pkg for the pixel type.
module fndf_judge (
    input  fndf_pkg::t_pix  i_self,
    input  logic [3:0][7:0] i_nb,
    input  logic [3:0]      i_nb_en,
    input  fndf_pkg::t_pix  i_tol,
    output fndf_pkg::t_pix  o_pixel,
    output logic            o_replaced
);
    import fndf_pkg::*;

    // 683 / 2048 is close enough to one third for every dividend below 2048.
    localparam logic [9:0] RECIP3 = 10'd683;

    logic [9:0] sum;
    logic [2:0] cnt;
    logic       near;
    t_pix       diff;
    logic       glitch;

    // Average rounded half up, (2*sum + n) / (2*n), for one to four neighbours.
    function automatic t_pix avg_half_up(input logic [9:0] s, input logic [2:0] n);
        logic [9:0]  s1;
        logic [9:0]  s2;
        logic [19:0] prod;
        t_pix        q;
        s1   = s + 10'd1;
        s2   = s + 10'd2;
        prod = 20'(s1) * 20'(RECIP3);
        unique case (n)
            3'd1:    q = s[7:0];
            3'd2:    q = s1[8:1];
            3'd3:    q = prod[18:11];
            3'd4:    q = s2[9:2];
            default: q = s[7:0];
        endcase
        return q;
    endfunction

    // Sum, count and closeness test over the neighbours that lie inside the frame.
    always_comb begin
        sum  = '0;
        cnt  = '0;
        near = 1'b0;
        diff = '0;
        for (int k = 0; k < 4; k++) begin
            diff = (i_self > i_nb[k]) ? (i_self - i_nb[k]) : (i_nb[k] - i_self);
            if (i_nb_en[k]) begin
                sum = sum + 10'(i_nb[k]);
                cnt = cnt + 3'd1;
                if (diff <= i_tol) begin
                    near = 1'b1;
                end
            end
        end
    end

    assign glitch     = (cnt != '0) && !near;
    assign o_replaced = glitch;
    assign o_pixel    = glitch ? avg_half_up(sum, cnt) : i_self;

endmodule

// ----- hdl/four_neighbour_deglitch_filter.sv -----
// Four-neighbour deglitch filter: impulse noise removal on a raster-order pixel stream.
// Uses fndf_pkg, fndf_ram, fndf_cell and fndf_judge.
//
// Pixels enter on the s_axis channel, one 8-bit pixel per beat, in raster order. Results
// leave on the m_axis channel: tdata carries the filtered pixel, tuser is high when the
// pixel was judged a glitch and replaced by its neighbour average, tlast marks the
// bottom-right pixel of the frame. Frame width, height and tolerance are set on the
// write port while the block is idle; a write to any of the three registers restarts the
// frame at row 0, column 0. Output lags input by one row: the pixel at row r-1 is judged
// once the pixel below it is accepted and leaves through the result queue. In ordinary
// rows one pixel is taken per cycle while the queue has room. In the last row each pixel
// after the first also releases a pixel of that row, so two results follow most inputs
// there and the single output beat per cycle sets the pace. A line store in one RAM holds
// the two previous rows; a chain of three column cells forms the window and three judge
// units evaluate its pixels. Reset empties the four-entry result queue and resets the
// position, flags and registers; the line store is not cleared, since a frame only reads
// entries written earlier in that frame. When the receiver stalls, results collect in the
// queue, and the input is held off once the queue cannot take the judge stage's results.
module four_neighbour_deglitch_filter #(
    parameter int MAX_WIDTH  = fndf_pkg::FNDF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fndf_pkg::FNDF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] pixel_out
    output logic                           m_axis_tuser,   // [0] replaced
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [fndf_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fndf_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import fndf_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int QD  = 4;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);
    localparam int PW  = $bits(t_pair);

    // Clamp a size register to 1..lim and return the index of the last position.
    function automatic int unsigned lim_last(input logic [CFG_W-1:0] v, input int unsigned lim);
        int unsigned t;
        if (v == '0) begin
            t = 1;
        end else if (32'(v) > lim) begin
            t = lim;
        end else begin
            t = 32'(v);
        end
        return t - 1;
    endfunction

    logic [AW-1:0]  r_col_last;
    logic [HW-1:0]  r_row_last;
    t_pix           r_tol;
    logic [AW-1:0]  r_col;
    logic [AW-1:0]  n_col;
    logic [HW-1:0]  r_row;
    logic [HW-1:0]  n_row;
    logic           acc;
    logic           cfg_hit;

    logic [PW-1:0]  ram_q;
    t_pair          rd_pair;
    t_pair          wr_pair;
    logic           r_fwd;
    t_pair          r_fwd_pair;

    t_col           cell_in  [3];
    t_col           cell_out [3];
    logic           r_jv;
    t_pos           r_jpos;

    t_pix           pix_a;
    t_pix           pix_b;
    t_pix           pix_c;
    logic           rep_a;
    logic           rep_b;
    logic           rep_c;
    logic           pa;
    logic           pb;
    logic           pc;
    logic [1:0]     n_j;
    logic           jload;
    t_res           res_a;
    t_res           res_b;
    t_res           res_c;
    logic [QPW-1:0] w_a;
    logic [QPW-1:0] w_b;
    logic [QPW-1:0] w_c;

    t_res           r_q [QD];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           pop;
    t_res           head;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign cfg_hit = i_cfg_we && ((i_cfg_addr == REG_IMAGE_WIDTH) ||
                                  (i_cfg_addr == REG_IMAGE_HEIGHT) ||
                                  (i_cfg_addr == REG_TOLERANCE));

    // Raster position of the next pixel.
    always_comb begin
        n_col = r_col + AW'(1);
        n_row = r_row;
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + HW'(1);
        end
    end

    // Configuration registers and raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= AW'(lim_last(RST_IMAGE_WIDTH, MAX_WIDTH));
            r_row_last <= HW'(lim_last(RST_IMAGE_HEIGHT, MAX_HEIGHT));
            r_tol      <= RST_TOLERANCE;
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_addr)
                REG_IMAGE_WIDTH:  r_col_last <= AW'(lim_last(i_cfg_wdata, MAX_WIDTH));
                REG_IMAGE_HEIGHT: r_row_last <= HW'(lim_last(i_cfg_wdata, MAX_HEIGHT));
                REG_TOLERANCE:    r_tol      <= i_cfg_wdata[7:0];
                default:          r_tol      <= r_tol;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store. Each beat writes its column and prefetches the next column, so the
    // right-hand neighbour is ready in the judge stage. With a one-pixel row the read
    // and the write meet at one address, and the written word is forwarded.
    assign rd_pair = r_fwd ? r_fwd_pair : t_pair'(ram_q);
    assign wr_pair = '{centre: s_axis_tdata, above: rd_pair.centre};

    fndf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_col),
        .i_wdata (wr_pair),
        .i_re    (acc),
        .i_raddr (n_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (acc) begin
            r_fwd <= (n_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fwd_pair <= wr_pair;
        end
    end

    // Window: the newest column enters cell 0 and moves one cell left per beat.
    assign cell_in[0] = '{up: rd_pair.above, mid: rd_pair.centre, low: s_axis_tdata};

    for (genvar g = 0; g < 3; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign cell_in[g] = cell_out[g-1];
        end
        fndf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (acc),
            .i_col   (cell_in[g]),
            .o_col   (cell_out[g])
        );
    end

    // Judge stage control: position flags of the column now in cell 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= 1'b0;
        end else if (acc) begin
            r_jv <= 1'b1;
        end else if (jload) begin
            r_jv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_jpos.row_ge1  <= (r_row != '0);
            r_jpos.row_ge2  <= (r_row != '0) && (r_row != HW'(1));
            r_jpos.row_last <= (r_row == r_row_last);
            r_jpos.col_ge1  <= (r_col != '0);
            r_jpos.col_ge2  <= (r_col != '0) && (r_col != AW'(1));
            r_jpos.col_last <= (r_col == r_col_last);
        end
    end

    // Pixel of the row above at the newest column. Neighbours: up, down, left, right.
    fndf_judge u_judge_a (
        .i_self     (cell_out[0].mid),
        .i_nb       ({rd_pair.centre, cell_out[1].mid, cell_out[0].low, cell_out[0].up}),
        .i_nb_en    ({!r_jpos.col_last, r_jpos.col_ge1, 1'b1, r_jpos.row_ge2}),
        .i_tol      (r_tol),
        .o_pixel    (pix_a),
        .o_replaced (rep_a)
    );

    // Last row only: pixel of the newest row one column back.
    fndf_judge u_judge_b (
        .i_self     (cell_out[1].low),
        .i_nb       ({cell_out[0].low, cell_out[2].low, 8'h00, cell_out[1].mid}),
        .i_nb_en    ({1'b1, r_jpos.col_ge2, 1'b0, r_jpos.row_ge1}),
        .i_tol      (r_tol),
        .o_pixel    (pix_b),
        .o_replaced (rep_b)
    );

    // Last row, last column: the bottom-right pixel of the frame.
    fndf_judge u_judge_c (
        .i_self     (cell_out[0].low),
        .i_nb       ({8'h00, cell_out[1].low, 8'h00, cell_out[0].mid}),
        .i_nb_en    ({1'b0, r_jpos.col_ge1, 1'b0, r_jpos.row_ge1}),
        .i_tol      (r_tol),
        .o_pixel    (pix_c),
        .o_replaced (rep_c)
    );

    assign pa    = r_jv && r_jpos.row_ge1;
    assign pb    = r_jv && r_jpos.row_last && r_jpos.col_ge1;
    assign pc    = r_jv && r_jpos.row_last && r_jpos.col_last;
    assign n_j   = 2'(pa) + 2'(pb) + 2'(pc);
    assign res_a = '{pixel: pix_a, replaced: rep_a, last: 1'b0};
    assign res_b = '{pixel: pix_b, replaced: rep_b, last: 1'b0};
    assign res_c = '{pixel: pix_c, replaced: rep_c, last: 1'b1};

    // The judge stage empties into the queue once all its results fit.
    assign jload = r_jv && ((QCW+1)'(r_cnt) + (QCW+1)'(n_j) <= (QCW+1)'(QD));
    assign s_axis_tready = !r_jv || jload;

    // Result queue: up to three entries written per cycle, in output order.
    assign w_a = r_wp;
    assign w_b = r_wp + QPW'(pa);
    assign w_c = r_wp + QPW'(pa) + QPW'(pb);
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            if (jload) begin
                if (pa && (w_a == QPW'(i))) begin
                    r_q[i] <= res_a;
                end else if (pb && (w_b == QPW'(i))) begin
                    r_q[i] <= res_b;
                end else if (pc && (w_c == QPW'(i))) begin
                    r_q[i] <= res_c;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + (jload ? QPW'(n_j) : '0);
            r_rp  <= r_rp + QPW'(pop);
            r_cnt <= r_cnt + (jload ? QCW'(n_j) : '0) - QCW'(pop);
        end
    end

    // Output beat comes straight from the queue head.
    assign head          = r_q[r_rp];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = head.pixel;
    assign m_axis_tuser  = head.replaced;
    assign m_axis_tlast  = head.last;

endmodule

// ----- hdl/fndf_checker.sv -----
// Port-level checks for the four-neighbour deglitch filter, bound to the top level.
// Sees only the top-level ports; no other dependencies.
module fndf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result beat changed or withdrawn while stalled");

    // Reset leaves an empty queue and an open input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not empty and ready after reset");

    // The input is only held off while results are waiting to leave.
    a_no_deadlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no result on offer");

endmodule

bind four_neighbour_deglitch_filter fndf_checker u_fndf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
